// ===== rtl/core/pwbb_pkg.sv =====
// Shared types, codes and constants for the PID controller with bang-bang override.
// No dependencies; imported by every module of the block.
package pwbb_pkg;

    // Operation codes carried in each input beat
    localparam logic [1:0] OP_RUN  = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_DRIVE_MIN = 3'd3;
    localparam logic [2:0] REG_DRIVE_MAX = 3'd4;
    localparam logic [2:0] REG_BANG_ON   = 3'd5;
    localparam logic [2:0] REG_BANG_OFF  = 3'd6;
    localparam logic [2:0] REG_STEP      = 3'd7;

    // Register reset values
    localparam logic [31:0] DRIVE_MAX_RST = 32'd6553600;
    localparam logic [31:0] STEP_RST      = 32'd1000000;

    // Trapezoid halves the sum and converts us to ms (divide by 2000 = shift by 4,
    // then divide by 125); derivative converts ms to us
    localparam logic [6:0]  DIV125_CONST  = 7'd125;
    localparam logic [23:0] DIV125_RECIP  = 24'd8589935;   // ceil(2^30 / 125)
    localparam logic [9:0]  DERIV_SCALE   = 10'd1000;

    // Iteration counts of the shared unit
    localparam int MUL_STEPS   = 32;
    localparam int DIV_STEPS   = 64;
    localparam int DIV2K_STEPS = 4;

    // Operating modes of the shared unit
    typedef enum logic [1:0] {
        MODE_MUL,
        MODE_DIV,
        MODE_DIV2K
    } unit_mode_t;

    // Jobs run on the shared multiply/divide unit, in order
    typedef enum logic [2:0] {
        JOB_INTEG_MUL,
        JOB_INTEG_DIV,
        JOB_DERIV_DIV,
        JOB_TERM_P,
        JOB_TERM_I,
        JOB_TERM_D
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_WAIT,
        ST_SUM,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic start;
        logic capture;
        logic sum;
        job_t job;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pid_go;
        logic unit_done;
    } dp_status_t;

endpackage

// ===== rtl/core/pwbb_muldiv.sv =====
// Shared iterative unit: 48x32 shift-add multiply, 64/32 restoring divide, or a
// divide by 2000 in 16-bit digits. Depends on pwbb_pkg for modes and step counts.
module pwbb_muldiv
    import pwbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  unit_mode_t  mode,
    input  logic [47:0] mul_a,
    input  logic [31:0] mul_b,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [79:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    unit_mode_t  mode_reg, mode_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [79:0] p_reg, p_next;
    logic [47:0] a_reg, a_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;

    logic [48:0] mul_sum;
    logic [32:0] rem_sh;
    logic        q_bit;
    logic [6:0]  last_cnt;
    logic [22:0] dig_cur;
    logic [46:0] dig_prod;
    logic [15:0] dig_q;
    logic [22:0] dig_back;
    logic [6:0]  dig_rem;

    // One multiply step: add multiplicand on the low bit, shift right
    assign mul_sum = {1'b0, p_reg[79:32]} + (p_reg[0] ? {1'b0, a_reg} : 49'd0);

    // One divide step: shift in the next dividend bit, subtract if it fits
    assign rem_sh = {rem_reg, p_reg[63]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});

    // One divide-by-125 digit: remainder (< 125) and next 16 bits, reciprocal multiply
    assign dig_cur  = {rem_reg[6:0], p_reg[63:48]};
    assign dig_prod = {24'd0, dig_cur} * {23'd0, DIV125_RECIP};
    assign dig_q    = dig_prod[45:30];
    assign dig_back = {7'd0, dig_q} * {16'd0, DIV125_CONST};
    assign dig_rem  = 7'(dig_cur - dig_back);

    assign last_cnt = (mode_reg == MODE_DIV)   ? 7'(DIV_STEPS - 1) :
                      (mode_reg == MODE_DIV2K) ? 7'(DIV2K_STEPS - 1) : 7'(MUL_STEPS - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            mode_next = mode;
            cnt_next  = 7'd0;
            a_next    = mul_a;
            dvs_next  = divisor;
            rem_next  = 32'd0;
            if (mode == MODE_DIV)
                p_next = {16'd0, dividend};
            else if (mode == MODE_DIV2K)
                p_next = {20'd0, dividend[63:4]};
            else
                p_next = {48'd0, mul_b};
        end
        else if (busy_reg)
        begin
            if (mode_reg == MODE_DIV)
            begin
                rem_next = q_bit ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
                p_next   = {16'd0, p_reg[62:0], q_bit};
            end
            else if (mode_reg == MODE_DIV2K)
            begin
                rem_next = {25'd0, dig_rem};
                p_next   = {16'd0, p_reg[47:0], dig_q};
            end
            else
            begin
                p_next = {mul_sum, p_reg[31:1]};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == last_cnt)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= MODE_MUL;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        a_reg   <= a_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done   = done_reg;
    assign result = p_reg;

endmodule

// ===== rtl/core/pwbb_datapath.sv =====
// Datapath: configuration registers, loop state, item decode and PID arithmetic.
// Depends on pwbb_pkg and instantiates pwbb_muldiv.
module pwbb_datapath
    import pwbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [1:0]         op,
    input  logic [31:0]        now_us,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] target,
    input  logic [30:0]        near_band,
    input  logic signed [47:0] integral_load,
    output logic signed [31:0] drive,
    output logic               drive_updated,
    output logic               at_setpoint,
    output logic               is_stopped,
    output logic signed [47:0] integral_now
);

    // Configuration
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] drive_min_reg, drive_max_reg;
    logic [30:0]        bang_on_reg, bang_off_reg;
    logic [31:0]        step_reg;

    // Loop state
    logic               stopped_reg, stopped_next;
    logic [31:0]        last_reg, last_next;
    logic signed [47:0] integ_reg, integ_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] drive_reg, drive_next;
    logic               upd_reg, upd_next;
    logic               near_reg, near_next;

    // Latched item
    logic [1:0]         op_reg;
    logic [31:0]        now_reg;
    logic signed [31:0] meas_reg, tgt_reg;
    logic [30:0]        nb_reg;
    logic signed [47:0] load_reg;

    // Per-update working values
    logic [31:0]        dt_reg, dt_next;
    logic signed [31:0] e_reg, e_next;
    logic [32:0]        smag_reg, smag_next;
    logic               sneg_reg, sneg_next;
    logic [41:0]        dnum_reg, dnum_next;
    logic               dneg_reg, dneg_next;
    logic [63:0]        tmp_reg, tmp_next;
    logic signed [31:0] deriv_reg, deriv_next;
    logic signed [31:0] tp_reg, tp_next, ti_reg, ti_next, td_reg, td_next;

    // Decode of the latched item
    logic signed [32:0] diff;
    logic [32:0]        abs_diff;
    logic               bang_on_hit, bang_off_hit;
    logic signed [31:0] e_sat, prev_eff;
    logic [31:0]        last_eff, dt;
    logic signed [32:0] s_sum, d_dif;
    logic [31:0]        d_mag;
    logic               pid_go;

    // Shared unit hookup
    unit_mode_t         u_mode;
    logic [47:0]        u_a;
    logic [31:0]        u_b, u_dvs;
    logic [63:0]        u_dvd;
    logic               u_done;
    logic [79:0]        u_res;

    // Capture helpers
    logic [48:0]        inc;
    logic signed [49:0] incs, isum;
    logic [63:0]        q;
    logic               t_neg;
    logic [63:0]        r_q;
    logic [31:0]        r_lim, r_sat;
    logic signed [33:0] total;
    logic signed [33:0] t_lo;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : v;
    endfunction

    // Item decode
    always_comb
    begin
        diff     = $signed({tgt_reg[31], tgt_reg}) - $signed({meas_reg[31], meas_reg});
        abs_diff = diff[32] ? 33'(-diff) : diff;
        bang_on_hit  = (bang_on_reg != 31'd0) && (diff > $signed({2'b00, bang_on_reg}));
        bang_off_hit = (bang_off_reg != 31'd0) && (diff < -$signed({2'b00, bang_off_reg}));
        if (diff[32] != diff[31])
            e_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            e_sat = diff[31:0];
        prev_eff = stopped_reg ? 32'sd0 : prev_reg;
        last_eff = stopped_reg ? now_reg : last_reg;
        dt       = now_reg - last_eff;
        s_sum    = $signed({e_sat[31], e_sat}) + $signed({prev_eff[31], prev_eff});
        d_dif    = $signed({e_sat[31], e_sat}) - $signed({prev_eff[31], prev_eff});
        d_mag    = d_dif[32] ? 32'(-d_dif) : d_dif[31:0];
        pid_go   = (op_reg == OP_RUN) && !bang_on_hit && !bang_off_hit && (dt >= step_reg);
    end

    // Operand selection for the shared unit
    always_comb
    begin
        u_mode = MODE_MUL;
        u_a    = 48'd0;
        u_b    = 32'd0;
        u_dvd  = 64'd0;
        u_dvs  = 32'd0;
        case (cmd.job)
            JOB_INTEG_MUL:
            begin
                u_a = {15'd0, smag_reg};
                u_b = dt_reg;
            end
            JOB_INTEG_DIV:
            begin
                u_mode = MODE_DIV2K;
                u_dvd  = tmp_reg;
            end
            JOB_DERIV_DIV:
            begin
                u_mode = MODE_DIV;
                u_dvd  = {22'd0, dnum_reg};
                u_dvs  = dt_reg;
            end
            JOB_TERM_P:
            begin
                u_a = {16'd0, mag32(e_reg)};
                u_b = mag32(gain_p_reg);
            end
            JOB_TERM_I:
            begin
                u_a = integ_reg[47] ? 48'(-integ_reg) : integ_reg;
                u_b = mag32(gain_i_reg);
            end
            JOB_TERM_D:
            begin
                u_a = {16'd0, mag32(deriv_reg)};
                u_b = mag32(gain_d_reg);
            end
            default:
            begin
                u_a = 48'd0;
            end
        endcase
    end

    pwbb_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .mode     (u_mode),
        .mul_a    (u_a),
        .mul_b    (u_b),
        .dividend (u_dvd),
        .divisor  (u_dvs),
        .done     (u_done),
        .result   (u_res)
    );

    // Result shaping for captures
    always_comb
    begin
        q    = u_res[63:0];
        inc  = (q > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : q[48:0];
        incs = sneg_reg ? -$signed({1'b0, inc}) : $signed({1'b0, inc});
        isum = $signed({{2{integ_reg[47]}}, integ_reg}) + incs;
        case (cmd.job)
            JOB_TERM_P: t_neg = e_reg[31] ^ gain_p_reg[31];
            JOB_TERM_I: t_neg = integ_reg[47] ^ gain_i_reg[31];
            JOB_TERM_D: t_neg = deriv_reg[31] ^ gain_d_reg[31];
            default:    t_neg = 1'b0;
        endcase
        r_q   = u_res[79:16];
        r_lim = t_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        r_sat = (r_q > {32'd0, r_lim}) ? r_lim : r_q[31:0];
        total = $signed({{2{tp_reg[31]}}, tp_reg}) + $signed({{2{ti_reg[31]}}, ti_reg})
              + $signed({{2{td_reg[31]}}, td_reg});
        t_lo  = (total < $signed({{2{drive_min_reg[31]}}, drive_min_reg}))
              ? $signed({{2{drive_min_reg[31]}}, drive_min_reg}) : total;
    end

    // State update
    always_comb
    begin
        stopped_next = stopped_reg;
        last_next    = last_reg;
        integ_next   = integ_reg;
        prev_next    = prev_reg;
        drive_next   = drive_reg;
        upd_next     = upd_reg;
        near_next    = near_reg;
        dt_next      = dt_reg;
        e_next       = e_reg;
        smag_next    = smag_reg;
        sneg_next    = sneg_reg;
        dnum_next    = dnum_reg;
        dneg_next    = dneg_reg;
        tmp_next     = tmp_reg;
        deriv_next   = deriv_reg;
        tp_next      = tp_reg;
        ti_next      = ti_reg;
        td_next      = td_reg;

        if (cmd.load)
            upd_next = 1'b0;

        if (cmd.eval)
        begin
            near_next = (abs_diff <= {2'b00, nb_reg});
            dt_next   = dt;
            e_next    = e_sat;
            smag_next = s_sum[32] ? 33'(-s_sum) : s_sum;
            sneg_next = s_sum[32];
            dnum_next = 42'(d_mag) * 42'(DERIV_SCALE);
            dneg_next = d_dif[32];
            case (op_reg)
                OP_RUN:
                begin
                    if (stopped_reg)
                    begin
                        stopped_next = 1'b0;
                        last_next    = now_reg;
                        integ_next   = 48'sd0;
                        prev_next    = 32'sd0;
                    end
                    if (bang_on_hit)
                    begin
                        drive_next = drive_max_reg;
                        last_next  = now_reg;
                        upd_next   = 1'b1;
                    end
                    else if (bang_off_hit)
                    begin
                        drive_next = drive_min_reg;
                        last_next  = now_reg;
                        upd_next   = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    stopped_next = 1'b1;
                    last_next    = now_reg;
                    integ_next   = 48'sd0;
                    prev_next    = 32'sd0;
                end
                OP_LOAD:
                begin
                    integ_next = load_reg;
                end
                default:
                begin
                    upd_next = 1'b0;
                end
            endcase
        end

        if (cmd.capture)
        begin
            case (cmd.job)
                JOB_INTEG_MUL: tmp_next = q;
                JOB_INTEG_DIV:
                begin
                    if (isum > $signed(50'sh0_7FFF_FFFF_FFFF))
                        integ_next = 48'sh7FFF_FFFF_FFFF;
                    else if (isum < -$signed(50'sh0_8000_0000_0000))
                        integ_next = 48'sh8000_0000_0000;
                    else
                        integ_next = isum[47:0];
                end
                JOB_DERIV_DIV:
                begin
                    if (dt_reg == 32'd0)
                        deriv_next = 32'sd0;
                    else if (dneg_reg)
                        deriv_next = (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q[31:0]);
                    else
                        deriv_next = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
                end
                JOB_TERM_P: tp_next = t_neg ? 32'(-r_sat) : r_sat;
                JOB_TERM_I: ti_next = t_neg ? 32'(-r_sat) : r_sat;
                JOB_TERM_D: td_next = t_neg ? 32'(-r_sat) : r_sat;
                default:    tmp_next = tmp_reg;
            endcase
        end

        // Final sum, clamp low then high
        if (cmd.sum)
        begin
            if (t_lo > $signed({{2{drive_max_reg[31]}}, drive_max_reg}))
                drive_next = drive_max_reg;
            else
                drive_next = t_lo[31:0];
            last_next = now_reg;
            prev_next = e_reg;
            upd_next  = 1'b1;
        end
    end

    // Configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= 32'sd0;
            gain_i_reg    <= 32'sd0;
            gain_d_reg    <= 32'sd0;
            drive_min_reg <= 32'sd0;
            drive_max_reg <= DRIVE_MAX_RST;
            bang_on_reg   <= 31'd0;
            bang_off_reg  <= 31'd0;
            step_reg      <= STEP_RST;
            stopped_reg   <= 1'b0;
            last_reg      <= 32'd0;
            integ_reg     <= 48'sd0;
            prev_reg      <= 32'sd0;
            drive_reg     <= 32'sd0;
            upd_reg       <= 1'b0;
            near_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GAIN_P:    gain_p_reg    <= cfg_data;
                    REG_GAIN_I:    gain_i_reg    <= cfg_data;
                    REG_GAIN_D:    gain_d_reg    <= cfg_data;
                    REG_DRIVE_MIN: drive_min_reg <= cfg_data;
                    REG_DRIVE_MAX: drive_max_reg <= cfg_data;
                    REG_BANG_ON:   bang_on_reg   <= cfg_data[30:0];
                    REG_BANG_OFF:  bang_off_reg  <= cfg_data[30:0];
                    REG_STEP:      step_reg      <= cfg_data;
                    default:       step_reg      <= step_reg;
                endcase
            end
            stopped_reg <= stopped_next;
            last_reg    <= last_next;
            integ_reg   <= integ_next;
            prev_reg    <= prev_next;
            drive_reg   <= drive_next;
            upd_reg     <= upd_next;
            near_reg    <= near_next;
        end
    end

    // Item latch and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            now_reg  <= now_us;
            meas_reg <= measured;
            tgt_reg  <= target;
            nb_reg   <= near_band;
            load_reg <= integral_load;
        end
        dt_reg    <= dt_next;
        e_reg     <= e_next;
        smag_reg  <= smag_next;
        sneg_reg  <= sneg_next;
        dnum_reg  <= dnum_next;
        dneg_reg  <= dneg_next;
        tmp_reg   <= tmp_next;
        deriv_reg <= deriv_next;
        tp_reg    <= tp_next;
        ti_reg    <= ti_next;
        td_reg    <= td_next;
    end

    assign status.pid_go    = pid_go;
    assign status.unit_done = u_done;

    assign drive         = drive_reg;
    assign drive_updated = upd_reg;
    assign at_setpoint   = near_reg;
    assign is_stopped    = stopped_reg;
    assign integral_now  = integ_reg;

endmodule

// ===== rtl/core/pwbb_ctrl.sv =====
// Controller: sequences item accept, decode, the six shared-unit jobs, sum and result beat.
// Depends on pwbb_pkg.
module pwbb_ctrl
    import pwbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    function automatic job_t job_succ(input job_t j);
        case (j)
            JOB_INTEG_MUL: job_succ = JOB_INTEG_DIV;
            JOB_INTEG_DIV: job_succ = JOB_DERIV_DIV;
            JOB_DERIV_DIV: job_succ = JOB_TERM_P;
            JOB_TERM_P:    job_succ = JOB_TERM_I;
            JOB_TERM_I:    job_succ = JOB_TERM_D;
            default:       job_succ = JOB_INTEG_MUL;
        endcase
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EVAL;
            ST_EVAL:
            begin
                job_next   = JOB_INTEG_MUL;
                state_next = status.pid_go ? ST_START : ST_OUT;
            end
            ST_START:
                state_next = ST_WAIT;
            ST_WAIT:
                if (status.unit_done)
                begin
                    if (job_reg == JOB_TERM_D)
                        state_next = ST_SUM;
                    else
                    begin
                        job_next   = job_succ(job_reg);
                        state_next = ST_START;
                    end
                end
            ST_SUM:
                state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        cmd.job     = job_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EVAL:  cmd.eval    = 1'b1;
            ST_START: cmd.start   = 1'b1;
            ST_WAIT:  cmd.capture = status.unit_done;
            ST_SUM:   cmd.sum     = 1'b1;
            ST_OUT:   out_valid   = 1'b1;
            default:  in_ready    = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_INTEG_MUL;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

endmodule

// ===== rtl/core/pid_with_bang_bang.sv =====
// Top level of the PID controller with bang-bang override.
// Depends on pwbb_pkg; instantiates pwbb_ctrl and pwbb_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | op, now_us, measured, target, near_band,
//          |                      | integral_load
//  out     | out_valid/ out_ready | drive, drive_updated, at_setpoint, is_stopped,
//          |                      | integral_now
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data (always ready)
//
// A bang, stop, load or skipped run beat goes from accept through ST_EVAL to ST_OUT,
// which raises out_valid.
// A PID update goes through ST_EVAL, the shared-unit jobs (multiplies, the 64-step
// divide and the divide by 2000) and ST_SUM before ST_OUT raises out_valid. One
// item at a time: in_ready is high only while idle, so no new beat is taken until
// the result is taken; a stalled result holds. Reset is asynchronous, active low,
// and loads the register defaults at once.
module pid_with_bang_bang
    import pwbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [31:0]        now_us,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] target,
    input  logic [30:0]        near_band,
    input  logic signed [47:0] integral_load,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive,
    output logic               drive_updated,
    output logic               at_setpoint,
    output logic               is_stopped,
    output logic signed [47:0] integral_now
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pwbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pwbb_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (op),
        .now_us        (now_us),
        .measured      (measured),
        .target        (target),
        .near_band     (near_band),
        .integral_load (integral_load),
        .drive         (drive),
        .drive_updated (drive_updated),
        .at_setpoint   (at_setpoint),
        .is_stopped    (is_stopped),
        .integral_now  (integral_now)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for pid_with_bang_bang: a scoreboard class predicts every result.
// Depends on pwbb_pkg and the RTL of the block; needs no other files.
module tb;
    import pwbb_pkg::*;

    typedef struct {
        logic signed [31:0] drive;
        logic               updated;
        logic               near;
        logic               stopped;
        logic signed [47:0] integ;
    } pid_result_t;

    // Predictor of the controller plus the queue of expected result beats
    class pid_scoreboard;
        logic signed [31:0] kp, ki, kd, dmin, dmax;
        logic [30:0]        on_band, off_band;
        logic [31:0]        period;
        bit                 stopped;
        logic [31:0]        last_t;
        longint             integ_acc, prev_err;
        logic signed [31:0] drv;
        pid_result_t        pending[$];
        int                 fails;

        function new();
            kp = 0; ki = 0; kd = 0; dmin = 0; dmax = DRIVE_MAX_RST;
            on_band = 0; off_band = 0; period = STEP_RST;
            stopped = 0; last_t = 0; integ_acc = 0; prev_err = 0; drv = 0;
            fails = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_GAIN_P:    kp = val;
                REG_GAIN_I:    ki = val;
                REG_GAIN_D:    kd = val;
                REG_DRIVE_MIN: dmin = val;
                REG_DRIVE_MAX: dmax = val;
                REG_BANG_ON:   on_band = val[30:0];
                REG_BANG_OFF:  off_band = val[30:0];
                default:       period = val;
            endcase
        endfunction

        function logic [63:0] magn(longint x);
            return x < 0 ? 64'(-x) : 64'(x);
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        // gain * value >> 16 toward zero, saturated to 32-bit signed
        function longint gain_term(longint g, longint v);
            logic [95:0] prod;
            logic [95:0] lim;
            bit          neg;
            neg  = (g < 0) != (v < 0);
            prod = {32'b0, magn(g)} * {32'b0, magn(v)};
            prod = prod >> 16;
            lim  = neg ? 96'd2147483648 : 96'd2147483647;
            if (prod > lim)
                prod = lim;
            return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        function void note_input(logic [1:0] op, logic [31:0] now, logic signed [31:0] meas,
                                 logic signed [31:0] tgt, logic [30:0] nb,
                                 logic signed [47:0] load);
            longint      diff, e, s, incs, deriv, total;
            logic [31:0] dt;
            logic [63:0] inc;
            pid_result_t r;
            diff = longint'(tgt) - longint'(meas);
            r.updated = 0;
            if (op == OP_RUN) begin
                if (stopped) begin
                    stopped = 0;
                    last_t = now; integ_acc = 0; prev_err = 0;
                end
                if (on_band != 0 && diff > longint'({1'b0, on_band})) begin
                    drv = dmax; last_t = now; r.updated = 1;
                end else if (off_band != 0 && -diff > longint'({1'b0, off_band})) begin
                    drv = dmin; last_t = now; r.updated = 1;
                end else begin
                    dt = now - last_t;
                    if (dt >= period) begin
                        e = clip(diff, -64'sd2147483648, 64'sd2147483647);
                        s = e + prev_err;
                        inc = (magn(s) * {32'b0, dt}) / 64'd2000;
                        if (inc > (64'd1 << 48))
                            inc = 64'd1 << 48;
                        incs = s < 0 ? -longint'(inc) : longint'(inc);
                        integ_acc = clip(integ_acc + incs, -(64'sd1 <<< 47),
                                         (64'sd1 <<< 47) - 1);
                        deriv = 0;
                        if (dt != 0)
                            deriv = clip(((e - prev_err) * 1000) / longint'({32'b0, dt}),
                                         -64'sd2147483648, 64'sd2147483647);
                        last_t = now;
                        prev_err = e;
                        total = gain_term(kp, e) + gain_term(ki, integ_acc)
                              + gain_term(kd, deriv);
                        if (total < longint'(dmin)) total = dmin;
                        if (total > longint'(dmax)) total = dmax;
                        drv = 32'(total);
                        r.updated = 1;
                    end
                end
            end else if (op == OP_STOP) begin
                stopped = 1;
                last_t = now; integ_acc = 0; prev_err = 0;
            end else if (op == OP_LOAD) begin
                integ_acc = load;
            end
            r.drive   = drv;
            r.near    = magn(diff) <= {33'b0, nb};
            r.stopped = stopped;
            r.integ   = integ_acc[47:0];
            pending.push_back(r);
        endfunction

        function void check_result(pid_result_t got);
            pid_result_t want;
            if (pending.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result beat: drive %0d", got.drive);
                return;
            end
            want = pending.pop_front();
            if (got.drive !== want.drive || got.updated !== want.updated ||
                got.near !== want.near || got.stopped !== want.stopped ||
                got.integ !== want.integ) begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: exp drive %0d upd %0b near %0b stop %0b integ %0d | got drive %0d upd %0b near %0b stop %0b integ %0d",
                             want.drive, want.updated, want.near, want.stopped, want.integ,
                             got.drive, got.updated, got.near, got.stopped, got.integ);
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [1:0]         op = OP_RUN;
    logic [31:0]        now_us = 0;
    logic signed [31:0] measured = 0;
    logic signed [31:0] target = 0;
    logic [30:0]        near_band = 0;
    logic signed [47:0] integral_load = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [31:0] drive;
    logic               drive_updated;
    logic               at_setpoint;
    logic               is_stopped;
    logic signed [47:0] integral_now;

    pid_scoreboard sb = new();
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic [31:0]   clock_us = 0;

    pid_with_bang_bang u_dut (.*);

    always #4 clk = ~clk;

    // Monitors: accepted input and result beats
    always @(posedge clk)
    begin
        pid_result_t got;
        if (in_valid && in_ready)
            sb.note_input(op, now_us, measured, target, near_band, integral_load);
        if (out_valid && out_ready) begin
            got.drive   = drive;
            got.updated = drive_updated;
            got.near    = at_setpoint;
            got.stopped = is_stopped;
            got.integ   = integral_now;
            sb.check_result(got);
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1; cfg_index = idx; cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic load_config(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                               logic [31:0] lo, logic [31:0] hi, logic [31:0] bon,
                               logic [31:0] boff, logic [31:0] per);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_DRIVE_MIN, lo);
        write_reg(REG_DRIVE_MAX, hi);
        write_reg(REG_BANG_ON, bon);
        write_reg(REG_BANG_OFF, boff);
        write_reg(REG_STEP, per);
    endtask

    // One input beat; called right after a falling edge
    task automatic send_beat(logic [1:0] o, logic [31:0] t, logic [31:0] m, logic [31:0] sp,
                             logic [30:0] nb, logic [47:0] ld);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1; op = o; now_us = t; measured = m; target = sp;
        near_band = nb; integral_load = ld;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Random beat: mostly run steps near the update period with values close to setpoint
    task automatic random_beat();
        int          r;
        logic [1:0]  o;
        logic [31:0] sp, m, span;
        logic [30:0] nb;
        logic [47:0] ld;
        r = $urandom_range(99);
        o = r < 80 ? OP_RUN : (r < 87 ? OP_STOP : (r < 94 ? OP_LOAD : 2'd3));
        span = sb.period > 4000 ? 32'd4000 : sb.period;
        r = $urandom_range(99);
        if (r < 70)
            clock_us = clock_us + sb.period + $urandom_range(0, span);
        else if (r < 85)
            clock_us = clock_us + $urandom_range(0, span);
        else if (r < 95)
            clock_us = clock_us + $urandom_range(0, 3);
        else
            clock_us = $urandom;
        if ($urandom_range(3) == 0) begin
            sp = $urandom; m = $urandom;
        end else begin
            sp = $urandom_range(0, 32'h00400000) - 32'h00200000;
            m  = sp + $urandom_range(0, 32'h00100000) - 32'h00080000;
        end
        nb = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(0, 32'h00040000));
        ld = $urandom_range(1) ? 48'({$urandom, $urandom})
                               : 48'($urandom_range(0, 32'h01000000)) - 48'h800000;
        send_beat(o, clock_us, m, sp, nb, ld);
    endtask

    // Timeout
    initial
    begin
        #200000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int ph;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: default registers, then extremes of every field and op
        send_beat(OP_RUN, 32'd0, 32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF, 48'd0);
        send_beat(OP_RUN, 32'd1000000, 32'd0, 32'sh00010000, 31'd0, 48'd0);
        send_beat(OP_LOAD, 32'd1000001, 32'd0, 32'd0, 31'd0, 48'h7FFFFFFFFFFF);
        send_beat(OP_LOAD, 32'd1000002, 32'd0, 32'd0, 31'd0, 48'h800000000000);
        send_beat(2'd3, 32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 48'hFFFFFF);
        drain();
        load_config(32'h00010000, 32'h00000100, 32'h00008000, 32'hFFF00000, 32'h00100000,
                    32'h00050000, 32'h00050000, 32'd10);
        send_beat(OP_RUN, 32'd100, 32'd0, 32'sh00060000, 31'd0, 48'd0);
        send_beat(OP_RUN, 32'd105, 32'sh00060000, 32'd0, 31'd0, 48'd0);
        send_beat(OP_RUN, 32'd110, 32'd0, 32'sh00020000, 31'h00010000, 48'd0);
        send_beat(OP_RUN, 32'd115, 32'd0, 32'sh00020000, 31'h00010000, 48'd0);
        send_beat(OP_RUN, 32'd130, 32'd0, 32'sh00010000, 31'h00010000, 48'd0);
        send_beat(OP_STOP, 32'd140, 32'd0, 32'd0, 31'd0, 48'd0);
        send_beat(OP_RUN, 32'd141, 32'd0, 32'sh00010000, 31'd0, 48'd0);
        send_beat(OP_RUN, 32'hFFFFFFF0, 32'd0, 32'sh00010000, 31'd0, 48'd0);
        send_beat(OP_RUN, 32'd20, 32'sh00010000, 32'd0, 31'd0, 48'd0);
        send_beat(OP_LOAD, 32'd21, 32'd0, 32'd0, 31'd0, 48'h7FFFFFFF0000);
        send_beat(OP_RUN, 32'd40, 32'd0, 32'sh00040000, 31'd0, 48'd0);
        drain();
        load_config(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h00000000, 32'h00000000, 32'd1);
        send_beat(OP_RUN, 32'd50, 32'sh80000000, 32'sh7FFFFFFF, 31'd0, 48'd0);
        send_beat(OP_RUN, 32'd51, 32'sh7FFFFFFF, 32'sh80000000, 31'd0, 48'd0);
        send_beat(OP_RUN, 32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 31'd0, 48'd0);
        drain();

        // Random phases: each with its own register setting and one of four idling modes
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_config(32'h00010000, 32'h00000040, 32'h00001000, 32'hFFF60000,
                               32'h000A0000, 32'h00080000, 32'h00080000, 32'd1000);
                1: load_config(32'h00008000, 32'h00000010, 32'h00000000, 32'd0,
                               32'h00640000, 32'd0, 32'd0, 32'd50);
                2: load_config($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom_range(1, 3000));
                3: load_config(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h00100000,
                               32'hFFF00000, 32'h7FFFFFFF, 32'h00000001, 32'd1);
                4: load_config(32'hFFFF0000, 32'h00000100, 32'hFFFFF000, 32'h80000000,
                               32'h7FFFFFFF, 32'h00000001, 32'h7FFFFFFF, 32'd200);
                5: load_config(32'h00020000, 32'hFFFFFF00, 32'h00004000, 32'hFFF00000,
                               32'h00100000, 32'h00100000, 32'h00100000, 32'hFFFFFFFF);
                6: load_config($urandom, $urandom_range(0, 1000), $urandom_range(0, 65536),
                               32'hFF000000, 32'h01000000, $urandom_range(0, 32'h200000),
                               $urandom_range(0, 32'h200000), $urandom_range(1, 100));
                default: load_config(32'h00010000, 32'h00000080, 32'h00000800, 32'hFFF00000,
                                     32'h00100000, 32'd0, 32'd0, 32'd10);
            endcase
            send_idle_pct  = (ph % 4 == 1) ? 70 : ((ph % 4 == 3) ? 35 : 0);
            recv_stall_pct = (ph % 4 == 2) ? 70 : ((ph % 4 == 3) ? 35 : 0);
            repeat (200) random_beat();
            drain();
        end

        if (sb.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/pwbb_pkg.sv
rtl/core/pwbb_muldiv.sv
rtl/core/pwbb_datapath.sv
rtl/core/pwbb_ctrl.sv
rtl/core/pid_with_bang_bang.sv
verif/tb.sv
